@@ rtl/tcrw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcrw_pkg
// Types and constants shared by the text console ring writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcrw_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_LINES   = 64;
  localparam int CELLS       = MAX_COLUMNS * MAX_LINES;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int CFG_W       = 7;
  localparam int LINE_W      = 6;
  localparam int DIV_N_W     = 12;
  localparam int DIV_D_W     = 7;

  localparam logic [CFG_W-1:0]  COLS_MAX   = CFG_W'(MAX_COLUMNS);
  localparam logic [CFG_W-1:0]  RING_MAX   = CFG_W'(MAX_LINES);
  localparam logic [CFG_W-1:0]  RING_MIN   = 7'd2;
  localparam logic [CFG_W-1:0]  COLS_RST   = 7'd64;
  localparam logic [CFG_W-1:0]  RING_RST   = 7'd64;
  localparam logic [LINE_W-1:0] VIS_RST    = 6'd32;

  localparam logic [15:0] CURSOR_MARK = 16'h02DB;
  localparam logic [7:0]  CHAR_ATTR   = 8'h02;

  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_RING    = 2'd1;
  localparam logic [1:0] CFG_VISIBLE = 2'd2;

  typedef enum logic {
    MODE_PUT  = 1'b0,
    MODE_READ = 1'b1
  } tcrw_mode_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  char_code;
    logic [11:0] read_index;
  } tcrw_cmd_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [11:0] cursor_index;
    logic [5:0]  top_line;
    logic        scrolled;
  } tcrw_res_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } tcrw_div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quot;
    logic [DIV_D_W-1:0] rem;
  } tcrw_div_rsp_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SETTLE,
    S_CUR_CHK,
    S_CUR_REQ,
    S_CUR_WAIT,
    S_FL_REQ,
    S_FL_WAIT,
    S_EXEC,
    S_READ,
    S_BS_CHK,
    S_SCROLL_CHK,
    S_CLEAR,
    S_MARK
  } tcrw_state_t;

endpackage

`default_nettype wire

@@ rtl/tcrw_cell_ram.sv @@
// ----------------------------------------------------------------------------
// tcrw_cell_ram
// Cell store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcrw_cell_ram
  import tcrw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [15:0]       wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [15:0]       rdata
);

  logic [15:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/tcrw_div_unit.sv @@
// ----------------------------------------------------------------------------
// tcrw_div_unit
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcrw_div_unit
  import tcrw_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tcrw_div_req_t req,
  output tcrw_div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(DIV_N_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_N_W - 1);

  logic               running;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_N_W-1:0] num;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] den;

  logic [DIV_D_W:0]   shifted;
  logic [DIV_D_W:0]   diff;
  logic               ge;
  logic [DIV_D_W-1:0] rem_next;

  always_comb begin
    shifted  = {rem, num[DIV_N_W-1]};
    ge       = shifted >= {1'b0, den};
    diff     = shifted - {1'b0, den};
    rem_next = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
        num     <= req.dividend;
        den     <= req.divisor;
        rem     <= '0;
      end else if (running) begin
        rem <= rem_next;
        num <= {num[DIV_N_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = num;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

@@ rtl/text_console_ring_writer_core.sv @@
// ----------------------------------------------------------------------------
// text_console_ring_writer_core
// Scrollback ring of 16-bit text cells with cursor and window tracking.
// ----------------------------------------------------------------------------
// When the window scrolls, the new line's cells are cleared before the mark.
// After any register write the next item first runs through the shared
// divider (cursor line/column, then first line wrap).
// One item at a time; a new start is taken on the cycle done is raised.
// Reset sweeps the 4096-cell store to zero with busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_ring_writer_core
  import tcrw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire tcrw_cmd_t        cmd,
  output tcrw_res_t             result,
  output logic                  done,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  tcrw_state_t state, state_next;

  logic [CFG_W-1:0]  columns, ring_lines;
  logic [LINE_W-1:0] visible_lines;

  logic              dirty, dirty_next;
  logic [ADDR_W-1:0] cursor, cursor_next;
  logic [LINE_W-1:0] cur_line, cur_line_next;
  logic [LINE_W-1:0] cur_col, cur_col_next;
  logic [LINE_W-1:0] first_line, first_line_next;
  logic [ADDR_W-1:0] init_addr, init_addr_next;

  logic [CFG_W-1:0]  eff_cols, eff_cols_next;
  logic [CFG_W-1:0]  eff_ring, eff_ring_next;
  logic [LINE_W-1:0] eff_vis, eff_vis_next;
  logic [ADDR_W:0]   area, area_next;

  tcrw_cmd_t         cmd_r, cmd_r_next;
  logic [ADDR_W-1:0] old_cursor, old_cursor_next;
  logic [LINE_W-1:0] old_line, old_line_next;
  logic [LINE_W-1:0] old_col, old_col_next;
  logic [LINE_W-1:0] clr_cnt, clr_cnt_next;
  logic              scrolled_r, scrolled_r_next;
  tcrw_res_t         result_next;
  logic              done_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [15:0]       ram_wdata, ram_rdata;

  tcrw_div_req_t div_req;
  tcrw_div_rsp_t div_rsp;

  logic [CFG_W-1:0]    cols_c, ring_c, vis_lim;
  logic [LINE_W-1:0]   vis_c;
  logic [2*CFG_W-1:0]  area_prod;
  logic [LINE_W-1:0]   nl_line;
  logic [2*CFG_W-1:0]  nl_prod;
  logic [CFG_W-1:0]    line_dist;
  logic [LINE_W-1:0]   fl_inc;

  tcrw_cell_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcrw_div_unit u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      columns       <= COLS_RST;
      ring_lines    <= RING_RST;
      visible_lines <= VIS_RST;
      dirty         <= 1'b1;
      cursor        <= '0;
      cur_line      <= '0;
      cur_col       <= '0;
      first_line    <= '0;
      init_addr     <= '0;
      done          <= 1'b0;
    end else begin
      state      <= state_next;
      dirty      <= dirty_next;
      cursor     <= cursor_next;
      cur_line   <= cur_line_next;
      cur_col    <= cur_col_next;
      first_line <= first_line_next;
      init_addr  <= init_addr_next;
      done       <= done_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLUMNS: columns       <= cfg_data;
          CFG_RING:    ring_lines    <= cfg_data;
          CFG_VISIBLE: visible_lines <= cfg_data[LINE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    eff_cols   <= eff_cols_next;
    eff_ring   <= eff_ring_next;
    eff_vis    <= eff_vis_next;
    area       <= area_next;
    cmd_r      <= cmd_r_next;
    old_cursor <= old_cursor_next;
    old_line   <= old_line_next;
    old_col    <= old_col_next;
    clr_cnt    <= clr_cnt_next;
    scrolled_r <= scrolled_r_next;
    result     <= result_next;
  end

  // register clamping
  always_comb begin
    if (columns == '0) begin
      cols_c = 7'd1;
    end else if (columns > COLS_MAX) begin
      cols_c = COLS_MAX;
    end else begin
      cols_c = columns;
    end
    if (ring_lines < RING_MIN) begin
      ring_c = RING_MIN;
    end else if (ring_lines > RING_MAX) begin
      ring_c = RING_MAX;
    end else begin
      ring_c = ring_lines;
    end
    vis_lim = ring_c - 7'd1;
    if (visible_lines == '0) begin
      vis_c = 6'd1;
    end else if ({1'b0, visible_lines} > vis_lim) begin
      vis_c = vis_lim[LINE_W-1:0];
    end else begin
      vis_c = visible_lines;
    end
    area_prod = cols_c * ring_c;
  end

  always_comb begin
    nl_line   = ({1'b0, cur_line} + 7'd1 == eff_ring) ? '0 : cur_line + 6'd1;
    nl_prod   = {1'b0, nl_line} * eff_cols;
    line_dist = (cur_line > first_line) ? ({1'b0, cur_line} - {1'b0, first_line})
                : (eff_ring + {1'b0, cur_line} - {1'b0, first_line});
    fl_inc    = ({1'b0, first_line} + 7'd1 == eff_ring) ? '0 : first_line + 6'd1;
  end

  always_comb begin
    state_next      = state;
    dirty_next      = dirty;
    cursor_next     = cursor;
    cur_line_next   = cur_line;
    cur_col_next    = cur_col;
    first_line_next = first_line;
    init_addr_next  = init_addr;
    eff_cols_next   = eff_cols;
    eff_ring_next   = eff_ring;
    eff_vis_next    = eff_vis;
    area_next       = area;
    cmd_r_next      = cmd_r;
    old_cursor_next = old_cursor;
    old_line_next   = old_line;
    old_col_next    = old_col;
    clr_cnt_next    = clr_cnt;
    scrolled_r_next = scrolled_r;
    result_next     = result;
    done_next       = 1'b0;

    ram_we    = 1'b0;
    ram_waddr = cursor;
    ram_wdata = '0;
    ram_raddr = cmd_r.read_index;

    div_req.start    = 1'b0;
    div_req.dividend = cursor;
    div_req.divisor  = eff_cols;

    unique case (state)
      S_INIT: begin
        ram_we         = 1'b1;
        ram_waddr      = init_addr;
        init_addr_next = init_addr + 1'b1;
        if (init_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_r_next      = cmd;
          scrolled_r_next = 1'b0;
          state_next      = dirty ? S_SETTLE : S_EXEC;
        end
      end
      S_SETTLE: begin
        eff_cols_next = cols_c;
        eff_ring_next = ring_c;
        eff_vis_next  = vis_c;
        area_next     = area_prod[ADDR_W:0];
        state_next    = S_CUR_CHK;
      end
      S_CUR_CHK: begin
        if ({1'b0, cursor} >= area) begin
          cursor_next   = '0;
          cur_line_next = '0;
          cur_col_next  = '0;
          state_next    = S_FL_REQ;
        end else begin
          state_next = S_CUR_REQ;
        end
      end
      S_CUR_REQ: begin
        div_req.start = 1'b1;
        state_next    = S_CUR_WAIT;
      end
      S_CUR_WAIT: begin
        if (div_rsp.done) begin
          cur_line_next = div_rsp.quot[LINE_W-1:0];
          cur_col_next  = div_rsp.rem[LINE_W-1:0];
          state_next    = S_FL_REQ;
        end
      end
      S_FL_REQ: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_N_W'(first_line);
        div_req.divisor  = eff_ring;
        state_next       = S_FL_WAIT;
      end
      S_FL_WAIT: begin
        div_req.dividend = DIV_N_W'(first_line);
        div_req.divisor  = eff_ring;
        if (div_rsp.done) begin
          first_line_next = div_rsp.rem[LINE_W-1:0];
          dirty_next      = 1'b0;
          state_next      = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_r.mode == MODE_READ) begin
          state_next = S_READ;
        end else if (cmd_r.char_code == CH_BS) begin
          ram_we          = 1'b1;
          old_cursor_next = cursor;
          old_line_next   = cur_line;
          old_col_next    = cur_col;
          if (cursor == '0) begin
            cursor_next   = ADDR_W'(area - 1'b1);
            cur_line_next = LINE_W'(eff_ring - 7'd1);
            cur_col_next  = LINE_W'(eff_cols - 7'd1);
          end else if (cur_col == '0) begin
            cursor_next   = cursor - 1'b1;
            cur_line_next = cur_line - 6'd1;
            cur_col_next  = LINE_W'(eff_cols - 7'd1);
          end else begin
            cursor_next  = cursor - 1'b1;
            cur_col_next = cur_col - 6'd1;
          end
          ram_raddr  = cursor_next;
          state_next = S_BS_CHK;
        end else if (cmd_r.char_code == CH_LF || cmd_r.char_code == CH_CR) begin
          ram_we        = 1'b1;
          cursor_next   = nl_prod[ADDR_W-1:0];
          cur_line_next = nl_line;
          cur_col_next  = '0;
          state_next    = S_SCROLL_CHK;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = {CHAR_ATTR, cmd_r.char_code};
          if ({1'b0, cur_col} + 7'd1 == eff_cols) begin
            cursor_next   = nl_prod[ADDR_W-1:0];
            cur_line_next = nl_line;
            cur_col_next  = '0;
            state_next    = S_SCROLL_CHK;
          end else begin
            cursor_next  = cursor + 1'b1;
            cur_col_next = cur_col + 6'd1;
            state_next   = S_MARK;
          end
        end
      end
      S_READ: begin
        result_next.read_data    = ({1'b0, cmd_r.read_index} < area) ? ram_rdata : '0;
        result_next.cursor_index = cursor;
        result_next.top_line     = first_line;
        result_next.scrolled     = 1'b0;
        done_next                = 1'b1;
        state_next               = S_IDLE;
      end
      S_BS_CHK: begin
        if (ram_rdata == '0) begin
          cursor_next   = old_cursor;
          cur_line_next = old_line;
          cur_col_next  = old_col;
        end
        state_next = S_MARK;
      end
      S_SCROLL_CHK: begin
        if (line_dist == {1'b0, eff_vis}) begin
          first_line_next = fl_inc;
          scrolled_r_next = 1'b1;
          clr_cnt_next    = '0;
          state_next      = S_CLEAR;
        end else begin
          state_next = S_MARK;
        end
      end
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = cursor + ADDR_W'(clr_cnt);
        clr_cnt_next = clr_cnt + 6'd1;
        if ({1'b0, clr_cnt} == eff_cols - 7'd1) begin
          state_next = S_MARK;
        end
      end
      S_MARK: begin
        ram_we                   = 1'b1;
        ram_wdata                = CURSOR_MARK;
        result_next.read_data    = '0;
        result_next.cursor_index = cursor;
        result_next.top_line     = first_line;
        result_next.scrolled     = scrolled_r;
        done_next                = 1'b1;
        state_next               = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase

    if (cfg_we) begin
      dirty_next = 1'b1;
    end
  end

  assign busy = (state != S_IDLE);

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in flight");

  a_start_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_cursor_in_area: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !dirty) |-> ({1'b0, cursor} < area))
    else $error("cursor outside the used area");

  a_top_in_ring: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !dirty) |-> ({1'b0, first_line} < eff_ring))
    else $error("first visible line outside the ring");

endmodule

`default_nettype wire
